@@ rtl/mcc_pkg.sv @@
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared constants, codes and controller/datapath interface types for the
// motion controller conditioner.
// ----------------------------------------------------------------------------
package mcc_pkg;

    localparam int HANDS_DEF   = 2;
    localparam int REPORT_RATE = 60;
    localparam int RATE_W      = $clog2(REPORT_RATE + 1);

    localparam int BTN_W   = 16;
    localparam int SEQ_W   = 8;
    localparam int POS_W   = 20;
    localparam int STICK_W = 16;
    localparam int VEL_W   = 32;
    localparam int ACC_W   = 40;

    // position difference, scaled velocity, scaled velocity difference
    localparam int PDIFF_W = POS_W + 1;
    localparam int VSC_W   = PDIFF_W + RATE_W;
    localparam int DIV_W   = VSC_W + 1 + RATE_W;
    localparam int DEN_W   = STICK_W + 1;

    localparam logic signed [STICK_W-1:0] STICK_MIN = {1'b1, {(STICK_W-1){1'b0}}};
    localparam logic signed [STICK_W-1:0] STICK_MAX = {1'b0, {(STICK_W-1){1'b1}}};

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] RECAL_NONE    = 2'd0;
    localparam logic [1:0] RECAL_DONE    = 2'd1;
    localparam logic [1:0] RECAL_REFUSED = 2'd2;

    typedef enum logic [1:0] {
        DSEL_JX  = 2'd0,
        DSEL_JY  = 2'd1,
        DSEL_VEL = 2'd2,
        DSEL_ACC = 2'd3
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     check;
        logic     div_start;
        div_sel_t div_sel;
        logic     store_jx;
        logic     store_jy;
        logic     store_vel;
        logic     store_acc;
        logic     axis_next;
        logic     commit;
    } mcc_cmd_t;

    typedef struct packed {
        logic process;
        logic div_done;
        logic last_axis;
    } mcc_sts_t;

endpackage

@@ rtl/motion_controller_conditioner.sv @@
// ----------------------------------------------------------------------------
// motion_controller_conditioner
// Per-hand tracker report conditioning: button edges, smoothing, velocity,
// acceleration and stick normalization.
// ----------------------------------------------------------------------------
// Input channel s_*: one tracker report per transfer. A report that is
// disabled, repeats the last sequence number of its hand, or names a hand
// of HANDS or more gives no result (ack still clears a valid hand's latches).
// Result channel m_*: a processed report gives three transfers, axis x, y, z,
// with m_last on z.
// Timing: one report at a time. A report is accepted and checked, then goes
// through 8 divides on the shared two-bit-per-cycle divider (2 stick, 3
// velocity, 3 acceleration) and three output transfers, plus any output
// stalls; the divider takes most of the time. A dropped report returns to
// idle straight after the check.
// s_ready is high only while the sequencer is idle.
// Reset clears all per-hand history to zero. While m_ready is low the
// result holds and no new divide starts.
// ----------------------------------------------------------------------------
module motion_controller_conditioner import mcc_pkg::*; #(
    parameter int HANDS = HANDS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_hand,
    input  logic                      s_enabled,
    input  logic [BTN_W-1:0]          s_buttons,
    input  logic [SEQ_W-1:0]          s_sequence_req,
    input  logic signed [POS_W-1:0]   s_pos_x,
    input  logic signed [POS_W-1:0]   s_pos_y,
    input  logic signed [POS_W-1:0]   s_pos_z,
    input  logic signed [STICK_W-1:0] s_stick_x,
    input  logic signed [STICK_W-1:0] s_stick_y,
    input  logic                      s_docked,
    input  logic                      s_ack_edges,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_out_hand,
    output logic [1:0]                m_axis,
    output logic signed [POS_W-1:0]   m_position,
    output logic signed [VEL_W-1:0]   m_velocity,
    output logic signed [ACC_W-1:0]   m_acceleration,
    output logic signed [STICK_W-1:0] m_joy_x,
    output logic signed [STICK_W-1:0] m_joy_y,
    output logic [BTN_W-1:0]          m_pressed,
    output logic [BTN_W-1:0]          m_released,
    output logic [SEQ_W-1:0]          m_elapsed_frames,
    output logic [1:0]                m_recalibrated,
    output logic                      m_last
);
    mcc_cmd_t cmd;
    mcc_sts_t sts;

    mcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mcc_datapath #(.HANDS(HANDS)) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_hand           (s_hand),
        .s_enabled        (s_enabled),
        .s_buttons        (s_buttons),
        .s_sequence_req   (s_sequence_req),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_pos_z          (s_pos_z),
        .s_stick_x        (s_stick_x),
        .s_stick_y        (s_stick_y),
        .s_docked         (s_docked),
        .s_ack_edges      (s_ack_edges),
        .m_out_hand       (m_out_hand),
        .m_axis           (m_axis),
        .m_position       (m_position),
        .m_velocity       (m_velocity),
        .m_acceleration   (m_acceleration),
        .m_joy_x          (m_joy_x),
        .m_joy_y          (m_joy_y),
        .m_pressed        (m_pressed),
        .m_released       (m_released),
        .m_elapsed_frames (m_elapsed_frames),
        .m_recalibrated   (m_recalibrated),
        .m_last           (m_last)
    );

    // no new report while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while result pending");

    a_last_on_z: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_axis == AXIS_Z)))
        else $error("last flag not on z axis");

    a_frames_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_elapsed_frames != '0))
        else $error("zero elapsed frames on a result");

    // axis steps by one between transfers of one report
    a_axis_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (m_axis == $past(m_axis) + 2'd1))
        else $error("axis order broken");

endmodule

@@ rtl/mcc_div.sv @@
// ----------------------------------------------------------------------------
// mcc_div
// Signed by unsigned restoring divider, two quotient bits per cycle,
// truncates toward zero.
// ----------------------------------------------------------------------------
module mcc_div import mcc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [DIV_W-1:0] dividend,
    input  logic        [DEN_W-1:0] divisor,
    output logic                    done,
    output logic signed [DIV_W-1:0] quotient
);
    localparam int STEPS = 2;
    localparam int ITER  = (DIV_W + STEPS - 1) / STEPS;
    localparam int CNT_W = $clog2(ITER + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic             neg_reg, neg_next;
    logic [DIV_W-1:0] q_t;
    logic [DEN_W:0]   r_t;

    always_comb begin
        q_t = q_reg;
        r_t = r_reg;
        for (int i = 0; i < STEPS; i++) begin
            r_t = {r_t[DEN_W-1:0], q_t[DIV_W-1]};
            q_t = {q_t[DIV_W-2:0], 1'b0};
            if (r_t >= {1'b0, d_reg}) begin
                r_t    = r_t - {1'b0, d_reg};
                q_t[0] = 1'b1;
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ITER);
            q_next    = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
            r_next    = '0;
            d_next    = divisor;
            neg_next  = dividend[DIV_W-1];
        end else if (busy_reg) begin
            q_next   = q_t;
            r_next   = r_t;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

@@ rtl/mcc_datapath.sv @@
// ----------------------------------------------------------------------------
// mcc_datapath
// Per-hand state, edge latches, recalibration, smoothing and the shared
// divider for velocity, acceleration and stick normalization.
// ----------------------------------------------------------------------------
module mcc_datapath import mcc_pkg::*; #(
    parameter int HANDS = HANDS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mcc_cmd_t                  cmd,
    output mcc_sts_t                  sts,
    input  logic                      s_hand,
    input  logic                      s_enabled,
    input  logic [BTN_W-1:0]          s_buttons,
    input  logic [SEQ_W-1:0]          s_sequence_req,
    input  logic signed [POS_W-1:0]   s_pos_x,
    input  logic signed [POS_W-1:0]   s_pos_y,
    input  logic signed [POS_W-1:0]   s_pos_z,
    input  logic signed [STICK_W-1:0] s_stick_x,
    input  logic signed [STICK_W-1:0] s_stick_y,
    input  logic                      s_docked,
    input  logic                      s_ack_edges,
    output logic                      m_out_hand,
    output logic [1:0]                m_axis,
    output logic signed [POS_W-1:0]   m_position,
    output logic signed [VEL_W-1:0]   m_velocity,
    output logic signed [ACC_W-1:0]   m_acceleration,
    output logic signed [STICK_W-1:0] m_joy_x,
    output logic signed [STICK_W-1:0] m_joy_y,
    output logic [BTN_W-1:0]          m_pressed,
    output logic [BTN_W-1:0]          m_released,
    output logic [SEQ_W-1:0]          m_elapsed_frames,
    output logic [1:0]                m_recalibrated,
    output logic                      m_last
);
    localparam int HIDX_W = (HANDS > 1) ? $clog2(HANDS) : 1;

    // captured report
    logic                      hand_reg, en_reg, dk_reg, ack_reg;
    logic [BTN_W-1:0]          btn_reg;
    logic [SEQ_W-1:0]          seq_reg;
    logic signed [POS_W-1:0]   raw_reg [3];
    logic signed [STICK_W-1:0] sx_reg, sy_reg;

    // per-hand state
    logic [BTN_W-1:0]          prev_btn_reg   [HANDS];
    logic [SEQ_W-1:0]          prev_seq_reg   [HANDS];
    logic signed [POS_W-1:0]   prev_raw_reg   [HANDS][3];
    logic                      prev_dk_reg    [HANDS];
    logic signed [POS_W-1:0]   prev_sm_reg    [HANDS][3];
    logic signed [VSC_W-1:0]   prev_vel_reg   [HANDS][3];
    logic signed [STICK_W-1:0] cx_reg         [HANDS];
    logic signed [STICK_W-1:0] cy_reg         [HANDS];
    logic [BTN_W-1:0]          pressed_reg    [HANDS];
    logic [BTN_W-1:0]          released_reg   [HANDS];

    // per-report results
    logic [1:0]                axis_reg;
    logic [SEQ_W-1:0]          frames_reg;
    logic [1:0]                recal_reg;
    logic signed [STICK_W-1:0] jx_reg, jy_reg;
    logic signed [POS_W-1:0]   pos_reg;
    logic signed [VSC_W-1:0]   vel_reg;
    logic signed [DIV_W-1:0]   acc_reg;

    logic [HIDX_W-1:0]         hidx;
    logic                      hand_ok;
    logic                      process;
    logic signed [PDIFF_W-1:0] sum, pdiff;
    logic signed [POS_W-1:0]   pos_cur;
    logic signed [VSC_W:0]     vdiff;
    logic signed [DIV_W-1:0]   vel_num, acc_num;
    logic signed [STICK_W-1:0] js, jc;
    logic signed [DEN_W:0]     jden;
    logic signed [DEN_W:0]     jdiff;
    logic signed [DIV_W-1:0]   j_num;
    logic                      j_zero;
    logic signed [DIV_W-1:0]   div_num;
    logic [DEN_W-1:0]          div_den;
    logic                      div_done;
    logic signed [DIV_W-1:0]   div_q;
    logic signed [STICK_W-1:0] j_sat;
    logic                      jx_zero_reg, jy_zero_reg, jzero_next;
    logic [BTN_W-1:0]          pr_base, rl_base;

    assign hidx    = HIDX_W'(hand_reg);
    assign hand_ok = (32'(hand_reg) < HANDS);
    assign process = hand_ok && en_reg && (seq_reg != prev_seq_reg[hidx]);

    // smoothing and scaled differences for the current axis
    assign sum     = PDIFF_W'(raw_reg[axis_reg]) + PDIFF_W'(prev_raw_reg[hidx][axis_reg]);
    assign pos_cur = POS_W'(sum >>> 1);
    assign pdiff   = PDIFF_W'(pos_cur) - PDIFF_W'(prev_sm_reg[hidx][axis_reg]);
    assign vel_num = DIV_W'(VSC_W'(pdiff) * VSC_W'(REPORT_RATE));
    assign vdiff   = (VSC_W+1)'(vel_reg) - (VSC_W+1)'(prev_vel_reg[hidx][axis_reg]);
    assign acc_num = DIV_W'(vdiff) * DIV_W'(REPORT_RATE);

    // stick normalization, piecewise around the center
    always_comb begin
        if (cmd.div_sel == DSEL_JY) begin
            js = sy_reg;
            jc = cy_reg[hidx];
        end else begin
            js = sx_reg;
            jc = cx_reg[hidx];
        end
        jdiff = (DEN_W+1)'(js) - (DEN_W+1)'(jc);
        if (js <= jc)
            jden = (DEN_W+1)'(jc) - (DEN_W+1)'(STICK_MIN);
        else
            jden = -(DEN_W+1)'(STICK_MIN) - (DEN_W+1)'(jc);
        j_zero = (jden <= 0);
        j_num  = DIV_W'(jdiff) <<< (STICK_W - 1);
    end

    always_comb begin
        unique case (cmd.div_sel)
            DSEL_JX, DSEL_JY: begin
                div_num = j_num;
                div_den = j_zero ? DEN_W'(1) : DEN_W'(jden);
            end
            DSEL_VEL: begin
                div_num = vel_num;
                div_den = DEN_W'(frames_reg);
            end
            DSEL_ACC: begin
                div_num = acc_num;
                div_den = DEN_W'(frames_reg);
            end
            default: begin
                div_num = vel_num;
                div_den = DEN_W'(frames_reg);
            end
        endcase
    end

    mcc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        if (div_q > DIV_W'(STICK_MAX))
            j_sat = STICK_MAX;
        else if (div_q < DIV_W'(STICK_MIN))
            j_sat = STICK_MIN;
        else
            j_sat = STICK_W'(div_q);
    end

    assign pr_base    = ack_reg ? '0 : pressed_reg[hidx];
    assign rl_base    = ack_reg ? '0 : released_reg[hidx];
    assign jzero_next = j_zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int h = 0; h < HANDS; h++) begin
                prev_btn_reg[h] <= '0;
                prev_seq_reg[h] <= '0;
                prev_dk_reg[h]  <= 1'b0;
                cx_reg[h]       <= '0;
                cy_reg[h]       <= '0;
                pressed_reg[h]  <= '0;
                released_reg[h] <= '0;
                for (int a = 0; a < 3; a++) begin
                    prev_raw_reg[h][a] <= '0;
                    prev_sm_reg[h][a]  <= '0;
                    prev_vel_reg[h][a] <= '0;
                end
            end
        end else begin
            if (cmd.check && hand_ok) begin
                if (process) begin
                    pressed_reg[hidx]  <= pr_base | (btn_reg & ~prev_btn_reg[hidx]);
                    released_reg[hidx] <= rl_base | (prev_btn_reg[hidx] & ~btn_reg);
                    if (prev_dk_reg[hidx] && !dk_reg &&
                        sx_reg != STICK_MIN && sy_reg != STICK_MIN) begin
                        cx_reg[hidx] <= sx_reg;
                        cy_reg[hidx] <= sy_reg;
                    end
                end else begin
                    pressed_reg[hidx]  <= pr_base;
                    released_reg[hidx] <= rl_base;
                end
            end
            if (cmd.store_vel)
                prev_sm_reg[hidx][axis_reg] <= pos_cur;
            if (cmd.store_acc)
                prev_vel_reg[hidx][axis_reg] <= vel_reg;
            if (cmd.commit) begin
                prev_btn_reg[hidx] <= btn_reg;
                prev_seq_reg[hidx] <= seq_reg;
                prev_dk_reg[hidx]  <= dk_reg;
                for (int a = 0; a < 3; a++)
                    prev_raw_reg[hidx][a] <= raw_reg[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            hand_reg   <= s_hand;
            en_reg     <= s_enabled;
            btn_reg    <= s_buttons;
            seq_reg    <= s_sequence_req;
            raw_reg[0] <= s_pos_x;
            raw_reg[1] <= s_pos_y;
            raw_reg[2] <= s_pos_z;
            sx_reg     <= s_stick_x;
            sy_reg     <= s_stick_y;
            dk_reg     <= s_docked;
            ack_reg    <= s_ack_edges;
        end
        if (cmd.check) begin
            axis_reg   <= AXIS_X;
            frames_reg <= seq_reg - prev_seq_reg[hidx];
            if (prev_dk_reg[hidx] && !dk_reg) begin
                if (sx_reg != STICK_MIN && sy_reg != STICK_MIN)
                    recal_reg <= RECAL_DONE;
                else
                    recal_reg <= RECAL_REFUSED;
            end else begin
                recal_reg <= RECAL_NONE;
            end
        end
        if (cmd.div_start && cmd.div_sel == DSEL_JX)
            jx_zero_reg <= jzero_next;
        if (cmd.div_start && cmd.div_sel == DSEL_JY)
            jy_zero_reg <= jzero_next;
        if (cmd.store_jx)
            jx_reg <= jx_zero_reg ? '0 : j_sat;
        if (cmd.store_jy)
            jy_reg <= jy_zero_reg ? '0 : j_sat;
        if (cmd.store_vel) begin
            pos_reg <= pos_cur;
            vel_reg <= VSC_W'(div_q);
        end
        if (cmd.store_acc)
            acc_reg <= div_q;
        if (cmd.axis_next)
            axis_reg <= axis_reg + 2'd1;
    end

    assign sts.process   = process;
    assign sts.div_done  = div_done;
    assign sts.last_axis = (axis_reg == AXIS_Z);

    assign m_out_hand       = hand_reg;
    assign m_axis           = axis_reg;
    assign m_position       = pos_reg;
    assign m_velocity       = VEL_W'(vel_reg);
    assign m_acceleration   = ACC_W'(acc_reg);
    assign m_joy_x          = jx_reg;
    assign m_joy_y          = jy_reg;
    assign m_pressed        = pressed_reg[hidx];
    assign m_released       = released_reg[hidx];
    assign m_elapsed_frames = frames_reg;
    assign m_recalibrated   = recal_reg;
    assign m_last           = (axis_reg == AXIS_Z);

endmodule

@@ rtl/mcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcc_ctrl
// Report sequencer: check, two stick divides, then per axis a velocity
// divide, an acceleration divide and one result transfer.
// ----------------------------------------------------------------------------
module mcc_ctrl import mcc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  mcc_sts_t sts,
    output mcc_cmd_t cmd
);
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_CHECK = 11'b00000000010,
        ST_JX    = 11'b00000000100,
        ST_JXW   = 11'b00000001000,
        ST_JY    = 11'b00000010000,
        ST_JYW   = 11'b00000100000,
        ST_VEL   = 11'b00001000000,
        ST_VELW  = 11'b00010000000,
        ST_ACC   = 11'b00100000000,
        ST_ACCW  = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DSEL_VEL;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = sts.process ? ST_JX : ST_IDLE;
            end
            ST_JX: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_JX;
                state_next    = ST_JXW;
            end
            ST_JXW: begin
                cmd.div_sel = DSEL_JX;
                if (sts.div_done) begin
                    cmd.store_jx = 1'b1;
                    state_next   = ST_JY;
                end
            end
            ST_JY: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_JY;
                state_next    = ST_JYW;
            end
            ST_JYW: begin
                cmd.div_sel = DSEL_JY;
                if (sts.div_done) begin
                    cmd.store_jy = 1'b1;
                    state_next   = ST_VEL;
                end
            end
            ST_VEL: begin
                cmd.div_start = 1'b1;
                state_next    = ST_VELW;
            end
            ST_VELW: begin
                if (sts.div_done) begin
                    cmd.store_vel = 1'b1;
                    state_next    = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_ACC;
                state_next    = ST_ACCW;
            end
            ST_ACCW: begin
                cmd.div_sel = DSEL_ACC;
                if (sts.div_done) begin
                    cmd.store_acc = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (sts.last_axis) begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.axis_next = 1'b1;
                        state_next    = ST_VEL;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motion controller conditioner. Drives tracker
// reports with random idling, predicts the per-axis results and compares
// every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb import mcc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               hand;
        logic               enabled;
        logic [BTN_W-1:0]   buttons;
        logic [SEQ_W-1:0]   seq;
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic [POS_W-1:0]   pz;
        logic [STICK_W-1:0] sx;
        logic [STICK_W-1:0] sy;
        logic               docked;
        logic               ack;
    } report_t;

    typedef struct packed {
        logic               hand;
        logic [1:0]         axis;
        logic [POS_W-1:0]   position;
        logic [VEL_W-1:0]   velocity;
        logic [ACC_W-1:0]   acceleration;
        logic [STICK_W-1:0] joy_x;
        logic [STICK_W-1:0] joy_y;
        logic [BTN_W-1:0]   pressed;
        logic [BTN_W-1:0]   released;
        logic [SEQ_W-1:0]   frames;
        logic [1:0]         recal;
        logic               last;
    } axis_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    report_t s_rep = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    axis_result_t got;

    report_t      pending_reports[$];
    axis_result_t expected_axes[$];
    int  errors = 0;
    int  hold_cycles = 0;
    bit  rx_idle_off = 1'b0;
    bit  tx_idle_off = 1'b0;

    // conditioner state per hand
    logic [BTN_W-1:0]   h_btn[2];
    logic [SEQ_W-1:0]   h_seq[2];
    longint             h_raw[2][3];
    logic               h_dock[2];
    longint             h_smooth[2][3];
    longint             h_vel[2][3];
    longint             h_centre[2][2];
    logic [BTN_W-1:0]   h_press[2];
    logic [BTN_W-1:0]   h_rel[2];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    motion_controller_conditioner u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_hand(s_rep.hand), .s_enabled(s_rep.enabled), .s_buttons(s_rep.buttons),
        .s_sequence_req(s_rep.seq), .s_pos_x(s_rep.px), .s_pos_y(s_rep.py),
        .s_pos_z(s_rep.pz), .s_stick_x(s_rep.sx), .s_stick_y(s_rep.sy),
        .s_docked(s_rep.docked), .s_ack_edges(s_rep.ack),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_hand(got.hand), .m_axis(got.axis), .m_position(got.position),
        .m_velocity(got.velocity), .m_acceleration(got.acceleration),
        .m_joy_x(got.joy_x), .m_joy_y(got.joy_y), .m_pressed(got.pressed),
        .m_released(got.released), .m_elapsed_frames(got.frames),
        .m_recalibrated(got.recal), .m_last(got.last)
    );

    function automatic longint clamp(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function automatic longint norm_stick(longint s, longint c);
        longint den;
        den = (s <= c) ? c + 32768 : 32768 - c;
        if (den <= 0) return 0;
        return clamp(((s - c) * 32768) / den, STICK_W);
    endfunction

    task automatic condition_report(input report_t r);
        int h;
        longint raw[3];
        longint sx, sy, jx, jy, sum, p, v, acc;
        logic [SEQ_W-1:0] frames;
        logic [1:0] recal;
        axis_result_t e;
        h = int'(r.hand);
        if (r.ack) begin
            h_press[h] = '0;
            h_rel[h] = '0;
        end
        if (!r.enabled || r.seq == h_seq[h]) return;
        raw[0] = longint'($signed(r.px));
        raw[1] = longint'($signed(r.py));
        raw[2] = longint'($signed(r.pz));
        sx = longint'($signed(r.sx));
        sy = longint'($signed(r.sy));
        h_press[h] |= r.buttons & ~h_btn[h];
        h_rel[h] |= h_btn[h] & ~r.buttons;
        frames = r.seq - h_seq[h];
        recal = RECAL_NONE;
        if (h_dock[h] && !r.docked) begin
            if (sx != -32768 && sy != -32768) begin
                h_centre[h][0] = sx;
                h_centre[h][1] = sy;
                recal = RECAL_DONE;
            end else begin
                recal = RECAL_REFUSED;
            end
        end
        jx = norm_stick(sx, h_centre[h][0]);
        jy = norm_stick(sy, h_centre[h][1]);
        for (int a = 0; a < 3; a++) begin
            sum = raw[a] + h_raw[h][a];
            p = (sum - (sum & 1)) / 2;
            v = clamp(((p - h_smooth[h][a]) * REPORT_RATE) / longint'(frames), VEL_W);
            acc = clamp(((v - h_vel[h][a]) * REPORT_RATE) / longint'(frames), ACC_W);
            h_smooth[h][a] = p;
            h_vel[h][a] = v;
            e.hand = r.hand;
            e.axis = (a == 0) ? AXIS_X : (a == 1) ? AXIS_Y : AXIS_Z;
            e.position = p[POS_W-1:0];
            e.velocity = v[VEL_W-1:0];
            e.acceleration = acc[ACC_W-1:0];
            e.joy_x = jx[STICK_W-1:0];
            e.joy_y = jy[STICK_W-1:0];
            e.pressed = h_press[h];
            e.released = h_rel[h];
            e.frames = frames;
            e.recal = recal;
            e.last = (a == 2);
            expected_axes.push_back(e);
        end
        h_btn[h] = r.buttons;
        h_seq[h] = r.seq;
        for (int a = 0; a < 3; a++) h_raw[h][a] = raw[a];
        h_dock[h] = r.docked;
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) condition_report(s_rep);
            if (!s_valid || s_ready) begin
                if (pending_reports.size() != 0 &&
                    (tx_idle_off || $urandom_range(99) >= 11)) begin
                    s_rep <= pending_reports.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        axis_result_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_axes.size() == 0) begin
                    $display("%0t: unexpected result transfer %h", $realtime, got);
                    errors++;
                end else begin
                    e = expected_axes.pop_front();
                    if (got !== e) begin
                        $display("%0t: mismatch expected %h actual %h", $realtime, e, got);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= rx_idle_off || $urandom_range(99) >= 11;
            end
        end
    end

    function automatic report_t rand_report(int h, logic [SEQ_W-1:0] seq);
        report_t r;
        r.hand = h[0];
        r.enabled = $urandom_range(99) < 90;
        r.buttons = BTN_W'($urandom);
        r.seq = seq;
        r.px = POS_W'($urandom);
        r.py = POS_W'($urandom);
        r.pz = POS_W'($urandom);
        case ($urandom_range(3))
            0: begin
                r.px = POS_W'($urandom_range(200) - 100);
                r.py = r.px + POS_W'(7);
                r.pz = -r.px;
            end
            default: ;
        endcase
        r.sx = ($urandom_range(9) == 0) ? STICK_MIN : STICK_W'($urandom);
        r.sy = ($urandom_range(9) == 0) ? STICK_MAX : STICK_W'($urandom);
        r.docked = $urandom_range(2) == 0;
        r.ack = $urandom_range(4) == 0;
        return r;
    endfunction

    initial begin
        report_t r;
        logic [SEQ_W-1:0] seqs[2];
        for (int h = 0; h < 2; h++) begin
            h_btn[h] = '0; h_seq[h] = '0; h_dock[h] = 1'b0;
            h_press[h] = '0; h_rel[h] = '0;
            h_centre[h][0] = 0; h_centre[h][1] = 0;
            for (int a = 0; a < 3; a++) begin
                h_raw[h][a] = 0; h_smooth[h][a] = 0; h_vel[h][a] = 0;
            end
        end
        // directed: extremes, repeats, disabled, dock transitions, wrap
        r = '0; r.enabled = 1'b1;
        r.seq = 8'd1; r.buttons = 16'hFFFF; r.px = 20'h7FFFF; r.py = 20'h80000;
        r.pz = 20'h00001; r.sx = STICK_MAX; r.sy = STICK_MIN; r.docked = 1'b1;
        pending_reports.push_back(r);
        r.seq = 8'd0; r.buttons = 16'h0000; r.px = 20'h80000; r.py = 20'h7FFFF;
        r.pz = 20'hFFFFF; r.docked = 1'b0; r.sx = STICK_MIN;
        pending_reports.push_back(r);                       // 255 frames, refused recal
        r.seq = 8'd0; r.ack = 1'b1; pending_reports.push_back(r);     // repeat + ack
        r.ack = 1'b0; r.seq = 8'd5; r.docked = 1'b1; r.enabled = 1'b0;
        pending_reports.push_back(r);                       // disabled
        r.enabled = 1'b1; pending_reports.push_back(r);
        r.seq = 8'd6; r.docked = 1'b0; r.sx = 16'sd32767; r.sy = 16'sd0;
        r.buttons = 16'hA5A5; pending_reports.push_back(r);          // recal at max
        r.seq = 8'd7; r.sx = STICK_MIN; r.sy = STICK_MAX; pending_reports.push_back(r);
        r.seq = 8'd8; r.sx = STICK_MAX; pending_reports.push_back(r);
        r.hand = 1'b1; r.seq = 8'd255; r.docked = 1'b1; r.px = 20'h7FFFF;
        r.py = 20'h7FFFF; r.pz = 20'h80000; r.buttons = 16'h5A5A;
        pending_reports.push_back(r);
        r.seq = 8'd0; r.docked = 1'b0; r.sx = STICK_MIN + 16'sd1;
        r.sy = STICK_MIN + 16'sd1;
        r.px = 20'h80000; r.py = 20'h80000; r.pz = 20'h7FFFF; pending_reports.push_back(r);
        r.seq = 8'd1; r.sx = STICK_MIN; r.sy = STICK_MAX; r.ack = 1'b1;
        pending_reports.push_back(r);
        seqs[0] = 8'd8; seqs[1] = 8'd1;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_off = 1'b1;
        rx_idle_off = 1'b1;
        wait (pending_reports.size() == 0);
        tx_idle_off = 1'b0;
        rx_idle_off = 1'b0;

        for (int i = 0; i < 420; i++) begin
            int h;
            h = $urandom_range(1);
            // mostly fresh sequence numbers; some repeats and big jumps
            case ($urandom_range(9))
                0: ;
                1: seqs[h] = seqs[h] + SEQ_W'($urandom_range(255));
                default: seqs[h] = seqs[h] + SEQ_W'($urandom_range(3, 1));
            endcase
            pending_reports.push_back(rand_report(h, seqs[h]));
            if (i == 60) begin
                // receiver holds off while the sender keeps offering
                wait (pending_reports.size() == 0);
                @(posedge aclk);
                hold_cycles <= 600;
            end
            if (i == 150) begin
                wait (pending_reports.size() == 0 && !s_valid);
                wait (expected_axes.size() == 0);
                repeat (200) @(posedge aclk);
            end
            if (i == 220) tx_idle_off = 1'b1;
            if (i == 300) begin
                wait (pending_reports.size() == 0);
                tx_idle_off = 1'b0;
                rx_idle_off = 1'b1;
            end
            if (i == 360) begin
                wait (pending_reports.size() == 0);
                rx_idle_off = 1'b0;
            end
        end
        wait (pending_reports.size() == 0 && !s_valid);
        wait (expected_axes.size() == 0);
        repeat (400) @(posedge aclk);
        if (errors == 0 && expected_axes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule

@@ files.f @@
rtl/mcc_pkg.sv
rtl/mcc_div.sv
rtl/mcc_datapath.sv
rtl/mcc_ctrl.sv
rtl/motion_controller_conditioner.sv
test/tb.sv
